>>> design/tm_transfer_frame_builder_macros.svh
// ----------------------------------------------------------------------------
// Transfer frame builder assertion macros
// Shared concurrent assertion forms used across the frame builder modules.
// ----------------------------------------------------------------------------
`ifndef TM_TRANSFER_FRAME_BUILDER_MACROS_SVH
`define TM_TRANSFER_FRAME_BUILDER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tmfb_pkg.sv
// ----------------------------------------------------------------------------
// Transfer frame builder package
// Shared types, register indexes and the CRC-16-CCITT byte update.
// ----------------------------------------------------------------------------
package tmfb_pkg;

  localparam logic [7:0]  IDLE_BYTE = 8'hE0;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [11:0] FRAME_LENGTH_RST = 12'd1115;

  typedef enum logic [2:0] {
    REG_SCID            = 3'd0,
    REG_VIRTUAL_CHANNEL = 3'd1,
    REG_FRAME_OPTIONS   = 3'd2,
    REG_FRAME_LENGTH    = 3'd3,
    REG_SEC_HDR_LENGTH  = 3'd4,
    REG_OCF_WORD        = 3'd5,
    REG_FIRST_HDR_PTR   = 3'd6
  } tmfb_reg_t;

  // frame_options bits
  localparam int OPT_OCF  = 0;
  localparam int OPT_SEC  = 1;
  localparam int OPT_SYNC = 2;
  localparam int OPT_CRC  = 3;

  typedef struct packed {
    logic [9:0]  scid;
    logic [2:0]  virtual_channel;
    logic [3:0]  frame_options;
    logic [11:0] frame_length;
    logic [5:0]  sec_header_length;
    logic [31:0] ocf_word;
    logic [10:0] first_header_pointer;
  } tmfb_cfg_t;

  // What the back end does with a queued slot
  typedef enum logic [1:0] {
    KIND_PLAIN  = 2'd0,
    KIND_CRC_HI = 2'd1,
    KIND_CRC_LO = 2'd2
  } tmfb_kind_t;

  typedef struct packed {
    tmfb_kind_t kind;
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       data_taken;
  } tmfb_cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> design/tmfb_front.sv
// ----------------------------------------------------------------------------
// Transfer frame builder front end
// Tracks the frame position and classifies each slot into a queued command.
// ----------------------------------------------------------------------------
`include "tm_transfer_frame_builder_macros.svh"

module tmfb_front #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tmfb_pkg::tmfb_cfg_t cfg,
  input  logic               accept,
  input  logic               data_valid,
  input  logic [7:0]         data_byte,
  input  logic [7:0]         master_count,
  output tmfb_pkg::tmfb_cmd_t cmd
);
  import tmfb_pkg::*;

  localparam int CAP   = (MAX_FRAME_BYTES < 4095) ? MAX_FRAME_BYTES : 4095;
  localparam int SPAN  = (CAP > 76) ? CAP : 76;
  localparam int POS_W = $clog2(SPAN + 1);
  localparam logic [11:0] CAP_L = 12'(CAP);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             fin_r, fin_nxt;
  logic [7:0]       mc_r, mc_nxt;

  logic             ocf_on, sec_on, sync_on, crc_on;
  logic [11:0]      len12;
  logic [POS_W-1:0] len, hdr, trl, ocf_len, ht, data_end, total, ocf_end, koff;
  logic [POS_W:0]   p1;
  logic             last;

  always_comb begin
    ocf_on  = cfg.frame_options[OPT_OCF];
    sec_on  = cfg.frame_options[OPT_SEC];
    sync_on = cfg.frame_options[OPT_SYNC];
    crc_on  = cfg.frame_options[OPT_CRC];

    len12   = (cfg.frame_length > CAP_L) ? CAP_L : cfg.frame_length;
    len     = POS_W'(len12);
    hdr     = sec_on ? POS_W'(7 + int'(cfg.sec_header_length)) : POS_W'(6);
    ocf_len = ocf_on ? POS_W'(4) : '0;
    trl     = ocf_len + (crc_on ? POS_W'(2) : '0);
    ht      = hdr + trl;
    // data field shrinks to nothing when headers and trailer fill the frame
    data_end = (len > ht) ? (len - trl) : hdr;
    total    = (len > ht) ? len : ht;
    ocf_end  = data_end + ocf_len;
    koff     = pos_r - data_end;
    p1       = {1'b0, pos_r} + 1'b1;
    last     = (p1 >= {1'b0, total});

    cmd.kind       = KIND_PLAIN;
    cmd.frame_byte = IDLE_BYTE;
    cmd.data_taken = 1'b0;
    cmd.frame_end  = last;
    fin_nxt        = fin_r;
    mc_nxt         = mc_r;

    priority if (pos_r == POS_W'(0)) begin
      mc_nxt         = master_count;
      cmd.frame_byte = {2'b00, cfg.scid[9:4]};
    end else if (pos_r == POS_W'(1)) begin
      cmd.frame_byte = {cfg.scid[3:0], cfg.virtual_channel, ocf_on};
    end else if (pos_r == POS_W'(2)) begin
      cmd.frame_byte = mc_r;
    end else if (pos_r == POS_W'(3)) begin
      cmd.frame_byte = 8'h00;
    end else if (pos_r == POS_W'(4)) begin
      // packet order bit stays clear, segment length id is all ones
      cmd.frame_byte = {sec_on, sync_on, 1'b0, 2'b11, cfg.first_header_pointer[10:8]};
    end else if (pos_r == POS_W'(5)) begin
      cmd.frame_byte = cfg.first_header_pointer[7:0];
    end else if (pos_r < hdr) begin
      if (pos_r == POS_W'(6)) begin
        cmd.frame_byte = {2'b00, cfg.sec_header_length};
      end else begin
        cmd.frame_byte = data_byte;
        cmd.data_taken = 1'b1;
      end
    end else if (pos_r < data_end) begin
      if (!fin_r && data_valid) begin
        cmd.frame_byte = data_byte;
        cmd.data_taken = 1'b1;
      end else begin
        fin_nxt = 1'b1;
      end
    end else if (pos_r < ocf_end) begin
      unique case (koff[1:0])
        2'd0:    cmd.frame_byte = cfg.ocf_word[31:24];
        2'd1:    cmd.frame_byte = cfg.ocf_word[23:16];
        2'd2:    cmd.frame_byte = cfg.ocf_word[15:8];
        default: cmd.frame_byte = cfg.ocf_word[7:0];
      endcase
    end else if (crc_on) begin
      cmd.kind = (pos_r == ocf_end) ? KIND_CRC_HI : KIND_CRC_LO;
    end else begin
      cmd.frame_byte = IDLE_BYTE;
    end

    if (last) begin
      pos_nxt = '0;
      fin_nxt = 1'b0;
    end else begin
      pos_nxt = p1[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      fin_r <= 1'b0;
      mc_r  <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      fin_r <= fin_nxt;
      mc_r  <= mc_nxt;
    end
  end

  // data stops only inside the data field, never on the first header byte
  `TMFB_ASSERT_NOW(a_fin_pos, clk, rst_n, fin_r, pos_r != POS_W'(0), "idle flag set at frame start")
  `TMFB_ASSERT_NEXT(a_wrap, clk, rst_n, accept && last, pos_r == POS_W'(0), "position did not wrap")

endmodule

>>> design/tmfb_queue.sv
// ----------------------------------------------------------------------------
// Transfer frame builder command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "tm_transfer_frame_builder_macros.svh"

module tmfb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tmfb_pkg::tmfb_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output tmfb_pkg::tmfb_cmd_t head
);
  import tmfb_pkg::*;

  tmfb_cmd_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  `TMFB_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full, "push into full queue")
  `TMFB_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, not_empty, "pop from empty queue")
  `TMFB_ASSERT_NOW(a_ptr_cnt, clk, rst_n, cnt_r == 2'd1, wr_ptr_r != rd_ptr_r, "pointers disagree with count")

endmodule

>>> design/tmfb_back.sv
// ----------------------------------------------------------------------------
// Transfer frame builder back end
// Runs the frame CRC, fills in the CRC bytes and drives the output register.
// ----------------------------------------------------------------------------
`include "tm_transfer_frame_builder_macros.svh"

module tmfb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  tmfb_pkg::tmfb_cmd_t q_head,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,   // [7:0] frame_byte
  output logic                out_tlast,   // frame_end
  output logic [0:0]          out_tuser    // [0] data_taken
);
  import tmfb_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic        vld_r;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, taken_r;

  assign q_pop = q_not_empty && (!vld_r || out_tready);

  always_comb begin
    crc_nxt  = crc_r;
    byte_nxt = q_head.frame_byte;
    unique case (q_head.kind)
      KIND_CRC_HI: byte_nxt = crc_r[15:8];
      KIND_CRC_LO: byte_nxt = crc_r[7:0];
      default:     crc_nxt  = crc_byte(crc_r, q_head.frame_byte);
    endcase
    // restart the CRC for the next frame
    if (q_head.frame_end) begin
      crc_nxt = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      vld_r <= 1'b0;
    end else begin
      if (q_pop) begin
        crc_r <= crc_nxt;
        vld_r <= 1'b1;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      byte_r  <= byte_nxt;
      last_r  <= q_head.frame_end;
      taken_r <= q_head.data_taken;
    end
  end

  assign out_tvalid   = vld_r;
  assign out_tdata    = byte_r;
  assign out_tlast    = last_r;
  assign out_tuser[0] = taken_r;

  `TMFB_ASSERT_NEXT(a_crc_restart, clk, rst_n, q_pop && q_head.frame_end, crc_r == CRC_INIT, "CRC not restarted after frame end")

endmodule

>>> design/tm_transfer_frame_builder.sv
// ----------------------------------------------------------------------------
// Telemetry transfer frame builder
// Emits one transfer frame byte per input transaction: primary header,
// optional secondary header, data or idle fill, optional OCF and CRC-16.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// in_      slave      tdata[7:0] data_byte, tdata[15:8] master_count, tuser[0] data_valid
// out_     master     tdata[7:0] frame_byte, tlast frame_end, tuser[0] data_taken
// cfg_     slave      cfg_index register index, cfg_data write value, always ready
//
// One input transaction per cycle while in_tready is high, one result per input;
// the front end writes each input into the queue, and the back end moves it into
// the output register. The rate is set by the front end position counter and the
// CRC byte update in the back end, each advancing once per cycle unless stalled.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output fills the two-entry queue, after which in_tready drops.
// ----------------------------------------------------------------------------
module tm_transfer_frame_builder #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [7:0] data_byte, [15:8] master_count
  input  logic [0:0]  in_tuser,    // [0] data_valid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] frame_byte
  output logic        out_tlast,   // frame_end
  output logic [0:0]  out_tuser,   // [0] data_taken
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tmfb_pkg::*;

  tmfb_cfg_t cfg_r;
  tmfb_cmd_t front_cmd, q_head;
  logic      in_accept, q_full, q_not_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scid                 <= '0;
      cfg_r.virtual_channel      <= '0;
      cfg_r.frame_options        <= '0;
      cfg_r.frame_length         <= FRAME_LENGTH_RST;
      cfg_r.sec_header_length    <= '0;
      cfg_r.ocf_word             <= '0;
      cfg_r.first_header_pointer <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCID:            cfg_r.scid                 <= cfg_data[9:0];
        REG_VIRTUAL_CHANNEL: cfg_r.virtual_channel      <= cfg_data[2:0];
        REG_FRAME_OPTIONS:   cfg_r.frame_options        <= cfg_data[3:0];
        REG_FRAME_LENGTH:    cfg_r.frame_length         <= cfg_data[11:0];
        REG_SEC_HDR_LENGTH:  cfg_r.sec_header_length    <= cfg_data[5:0];
        REG_OCF_WORD:        cfg_r.ocf_word             <= cfg_data;
        REG_FIRST_HDR_PTR:   cfg_r.first_header_pointer <= cfg_data[10:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  tmfb_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .accept       (in_accept),
    .data_valid   (in_tuser[0]),
    .data_byte    (in_tdata[7:0]),
    .master_count (in_tdata[15:8]),
    .cmd          (front_cmd)
  );

  tmfb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  tmfb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule
